// ===== hdl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int REQ_W   = 3;
   localparam int WORD_W  = 32;
   localparam int CAP_W   = 5;

   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture the request
      logic exec;   // apply the operation
      logic read;   // read front and rear, capture flags
   } cmd_type;

endpackage

// ===== hdl/bounded_double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// An accepted request steps through execute, memory read and respond; the response
// strobe is raised in respond, and the next request is taken while responding.
// Reset: queue empty, head at slot zero, capacity 16; storage is not cleared.
// Responses cannot be stalled.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top import bdq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [REQ_W-1:0]         req_type,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   output logic                     rsp_strobe,
   output logic                     rsp_ok,
   output logic signed [WORD_W-1:0] rsp_front_value,
   output logic signed [WORD_W-1:0] rsp_rear_value,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   cmd_type cmd;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_value       (req_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

// ===== hdl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: capture, execute, read, respond.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_strobe,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy       = (state_ff == ST_EXEC) || (state_ff == ST_READ);
   assign rsp_strobe = (state_ff == ST_RESP);
   assign accept     = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_READ;
         ST_READ: state_in = ST_RESP;
         ST_RESP: state_in = accept ? ST_EXEC : ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load = accept;
      cmd.exec = (state_ff == ST_EXEC);
      cmd.read = (state_ff == ST_READ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/bdq_dpath.sv =====
// ----------------------------------------------------------------------------
// bdq_dpath
// Ring buffer storage, head and occupancy registers, response registers.
// ----------------------------------------------------------------------------
module bdq_dpath import bdq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [REQ_W-1:0]         req_type,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   output logic                     rsp_ok,
   output logic signed [WORD_W-1:0] rsp_front_value,
   output logic signed [WORD_W-1:0] rsp_rear_value,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam int CW = (OW > CAP_W) ? OW : CAP_W;
   localparam int SW = AW + 2;

   logic [WORD_W-1:0] mem [DEPTH];

   logic [CAP_W-1:0]  cap_ff;
   logic [AW-1:0]     head_ff,  head_in;
   logic [OW-1:0]     occ_ff,   occ_in;
   logic [REQ_W-1:0]  req_ff;
   logic [WORD_W-1:0] value_ff;
   logic              ok_ff,    ok_in;
   logic              empty_ff, full_ff;
   logic [WORD_W-1:0] front_rd_ff, rear_rd_ff;

   logic [CW-1:0] cap_ext, cap_eff, occ_cw;
   logic          full, empty;
   logic [SW-1:0] head_s, back_sum, inc_sum, rear_sum, depth_s;
   logic [OW-1:0] occ_m1;
   logic [AW-1:0] head_dec, head_inc, back_slot, rear_slot, wr_addr;
   logic          wr_en;

   always_comb begin
      cap_ext = CW'(cap_ff);
      cap_eff = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
      occ_cw  = CW'(occ_ff);
      full    = (occ_cw >= cap_eff);
      empty   = (occ_ff == '0);

      depth_s  = SW'(DEPTH);
      head_s   = SW'(head_ff);
      occ_m1   = empty ? '0 : occ_ff - 1'b1;
      back_sum = head_s + SW'(occ_ff);
      inc_sum  = head_s + SW'(1);
      rear_sum = head_s + SW'(occ_m1);

      back_slot = (back_sum >= depth_s) ? AW'(back_sum - depth_s) : AW'(back_sum);
      head_inc  = (inc_sum  >= depth_s) ? AW'(inc_sum  - depth_s) : AW'(inc_sum);
      rear_slot = (rear_sum >= depth_s) ? AW'(rear_sum - depth_s) : AW'(rear_sum);
      head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   end

   always_comb begin
      head_in = head_ff;
      occ_in  = occ_ff;
      ok_in   = 1'b0;
      wr_en   = 1'b0;
      wr_addr = back_slot;
      unique case (req_ff)
         REQ_PUSH_FRONT: begin
            if (!full) begin
               head_in = head_dec;
               occ_in  = occ_ff + 1'b1;
               ok_in   = 1'b1;
               wr_en   = 1'b1;
               wr_addr = head_dec;
            end
         end
         REQ_PUSH_BACK: begin
            if (!full) begin
               occ_in = occ_ff + 1'b1;
               ok_in  = 1'b1;
               wr_en  = 1'b1;
            end
         end
         REQ_POP_FRONT: begin
            if (!empty) begin
               head_in = head_inc;
               occ_in  = occ_ff - 1'b1;
               ok_in   = 1'b1;
            end
         end
         REQ_POP_BACK: begin
            if (!empty) begin
               occ_in = occ_ff - 1'b1;
               ok_in  = 1'b1;
            end
         end
         REQ_QUERY: ok_in = 1'b1;
         default:   ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         head_ff <= '0;
         occ_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.exec) begin
            head_ff <= head_in;
            occ_ff  <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_type;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         ok_ff <= ok_in;
      end
      if (cmd.read) begin
         empty_ff <= empty;
         full_ff  <= full;
      end
   end

   // storage: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.read) begin
         front_rd_ff <= mem[head_ff];
         rear_rd_ff  <= mem[rear_slot];
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;
   assign rsp_front_value = empty_ff ? '1 : front_rd_ff;
   assign rsp_rear_value  = empty_ff ? '1 : rear_rd_ff;

endmodule

// ===== hdl/bdq_checker.sv =====
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic                     rsp_is_empty,
   input logic signed [WORD_W-1:0] rsp_front_value,
   input logic signed [WORD_W-1:0] rsp_rear_value
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted request");

   a_resp_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_strobe)
      else $error("response not issued three cycles after request");

   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response strobe while busy");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_empty |-> (rsp_front_value == -32'sd1) &&
                                     (rsp_rear_value == -32'sd1))
      else $error("empty queue reports values other than all ones");

endmodule

bind bounded_double_ended_queue_top bdq_checker u_bdq_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks bounded_double_ended_queue_top against a ring-buffer predictor.
// A directed table covers empty and full queues, word extremes, unused
// codes and capacity changes (zero, saturating, lowered below occupancy).
// Random phases follow, each setting its capacity first. Each response is compared
// field by field with the oldest expected response.
// ----------------------------------------------------------------------------
module testbench;
   import bdq_pkg::*;

   localparam int DEPTH           = 16;
   localparam int ITEMS_PER_PHASE = 96;
   localparam int NUM_PHASES      = 12;
   localparam int STALL_LIMIT     = 1000;

   localparam logic [REQ_W-1:0]  REQ_RSVD_A   = 3'd5;
   localparam logic [REQ_W-1:0]  REQ_RSVD_B   = 3'd6;
   localparam logic [REQ_W-1:0]  REQ_RSVD_C   = 3'd7;
   localparam logic [REQ_W-1:0]  REQ_CODE_MAX = '1;
   localparam logic [WORD_W-1:0] NO_ENTRY     = '1;

   typedef struct packed {
      logic              ok;
      logic [WORD_W-1:0] front;
      logic [WORD_W-1:0] rear;
      logic              empty;
      logic              full;
   } queue_view_type;

   typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [CAP_W-1:0]  cap;
      logic [REQ_W-1:0]  op;
      logic [WORD_W-1:0] word;
      logic              typed;
      queue_view_type    want;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [26] = '{
      '{ROW_REQUEST,  5'd0,  REQ_QUERY,      32'h0000_0000, 1'b1,
        '{1'b1, NO_ENTRY, NO_ENTRY, 1'b1, 1'b0}},
      '{ROW_REQUEST,  5'd0,  REQ_POP_FRONT,  32'h0000_0000, 1'b1,
        '{1'b0, NO_ENTRY, NO_ENTRY, 1'b1, 1'b0}},
      '{ROW_REQUEST,  5'd0,  REQ_POP_BACK,   32'hFFFF_FFFF, 1'b1,
        '{1'b0, NO_ENTRY, NO_ENTRY, 1'b1, 1'b0}},
      '{ROW_REQUEST,  5'd0,  REQ_RSVD_A,     32'h1234_5678, 1'b1,
        '{1'b0, NO_ENTRY, NO_ENTRY, 1'b1, 1'b0}},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1,
        '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0}},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_FRONT, 32'h8000_0000, 1'b1,
        '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_RSVD_B,     32'hDEAD_BEEF, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_RSVD_C,     32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_CAPACITY, 5'd2,  REQ_QUERY,      32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_FRONT, 32'h8765_4321, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_QUERY,      32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_POP_BACK,   32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_POP_FRONT,  32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_POP_FRONT,  32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_POP_BACK,   32'h0000_0000, 1'b1,
        '{1'b1, NO_ENTRY, NO_ENTRY, 1'b1, 1'b0}},
      '{ROW_CAPACITY, 5'd0,  REQ_QUERY,      32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_FRONT, 32'h0000_0001, 1'b1,
        '{1'b0, NO_ENTRY, NO_ENTRY, 1'b1, 1'b1}},
      '{ROW_REQUEST,  5'd0,  REQ_QUERY,      32'h0000_0000, 1'b1,
        '{1'b1, NO_ENTRY, NO_ENTRY, 1'b1, 1'b1}},
      '{ROW_CAPACITY, 5'd31, REQ_QUERY,      32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_BACK,  32'hAAAA_AAAA, 1'b1,
        '{1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b0}},
      '{ROW_REQUEST,  5'd0,  REQ_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_POP_BACK,   32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST,  5'd0,  REQ_POP_FRONT,  32'h0000_0000, 1'b1,
        '{1'b1, NO_ENTRY, NO_ENTRY, 1'b1, 1'b0}}
   };

   localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] =
      '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd15, 5'd17, 5'd3, 5'd8, 5'd2, 5'd12, 5'd16};

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [REQ_W-1:0]         req_type;
   logic signed [WORD_W-1:0] req_value;
   logic                     csr_wr_en;
   logic [CAP_W-1:0]         csr_wr_data;
   logic                     rsp_strobe;
   logic                     rsp_ok;
   logic signed [WORD_W-1:0] rsp_front_value;
   logic signed [WORD_W-1:0] rsp_rear_value;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   // predictor state
   logic [WORD_W-1:0] ring_slots [DEPTH];
   int                ring_head  = 0;
   int                ring_count = 0;
   logic [CAP_W-1:0]  capacity_reg = CAP_RESET;

   queue_view_type pending_results [$];
   int             mismatch_count = 0;
   int             stall_cycles   = 0;

   bounded_double_ended_queue_top #(.DEPTH(DEPTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_value       (req_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic queue_view_type apply_request(logic [REQ_W-1:0] op,
                                                    logic [WORD_W-1:0] word);
      int             limit;
      bit             at_limit;
      queue_view_type view;
      limit    = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
      at_limit = ring_count >= limit;
      view.ok  = 1'b0;
      case (op)
         REQ_PUSH_FRONT: begin
            if (!at_limit) begin
               ring_head = (ring_head + DEPTH - 1) % DEPTH;
               ring_slots[ring_head] = word;
               ring_count++;
               view.ok = 1'b1;
            end
         end
         REQ_PUSH_BACK: begin
            if (!at_limit) begin
               ring_slots[(ring_head + ring_count) % DEPTH] = word;
               ring_count++;
               view.ok = 1'b1;
            end
         end
         REQ_POP_FRONT: begin
            if (ring_count != 0) begin
               ring_head = (ring_head + 1) % DEPTH;
               ring_count--;
               view.ok = 1'b1;
            end
         end
         REQ_POP_BACK: begin
            if (ring_count != 0) begin
               ring_count--;
               view.ok = 1'b1;
            end
         end
         REQ_QUERY: view.ok = 1'b1;
         default:   view.ok = 1'b0;
      endcase
      if (ring_count == 0) begin
         view.front = NO_ENTRY;
         view.rear  = NO_ENTRY;
      end else begin
         view.front = ring_slots[ring_head];
         view.rear  = ring_slots[(ring_head + ring_count - 1) % DEPTH];
      end
      view.empty = ring_count == 0;
      view.full  = ring_count >= limit;
      return view;
   endfunction

   function automatic logic [REQ_W-1:0] pick_op(bit filling);
      int roll;
      roll = $urandom_range(99);
      if (filling) begin
         if (roll < 35)      return REQ_PUSH_FRONT;
         else if (roll < 65) return REQ_PUSH_BACK;
         else if (roll < 78) return REQ_POP_FRONT;
         else if (roll < 90) return REQ_POP_BACK;
         else if (roll < 95) return REQ_QUERY;
      end else begin
         if (roll < 20)      return REQ_PUSH_FRONT;
         else if (roll < 40) return REQ_PUSH_BACK;
         else if (roll < 62) return REQ_POP_FRONT;
         else if (roll < 84) return REQ_POP_BACK;
         else if (roll < 93) return REQ_QUERY;
      end
      return REQ_W'($urandom_range(REQ_QUERY + 1, REQ_CODE_MAX));
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic issue_request(input logic [REQ_W-1:0] op, input logic [WORD_W-1:0] word,
                                input logic typed, input queue_view_type typed_view);
      queue_view_type view;
      start     <= 1'b1;
      req_type  <= op;
      req_value <= word;
      do @(posedge clock); while (busy !== 1'b0);
      view = apply_request(op, word);
      pending_results.push_back(typed ? typed_view : view);
   endtask

   task automatic pause_requests();
      start     <= 1'b0;
      req_type  <= REQ_W'($urandom);
      req_value <= $urandom;
      repeat ($urandom_range(1, 3)) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      capacity_reg  = cap;
   endtask

   task automatic report_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_responses
      queue_view_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, actual %h",
                     $time, rsp_front_value);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("ok",          want.ok,    rsp_ok);
            report_field("front_value", want.front, rsp_front_value);
            report_field("rear_value",  want.rear,  rsp_rear_value);
            report_field("is_empty",    want.empty, rsp_is_empty);
            report_field("is_full",     want.full,  rsp_is_full);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or response for %0d cycles", $time, STALL_LIMIT);
         $display("** bounded_double_ended_queue_top: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      bit may_idle;
      reset       = 1'b1;
      start       = 1'b0;
      req_type    = REQ_QUERY;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = CAP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_CAPACITY) begin
            write_capacity(DIRECTED_ROWS[i].cap);
         end else begin
            issue_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].word,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
         end
      end

      // fill-heavy start of each phase so entries carry into the next capacity
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_capacity(PHASE_CAPS[phase]);
         may_idle = (phase != 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            issue_request(pick_op(n < ITEMS_PER_PHASE * 6 / 10), pick_word(), 1'b0, '0);
            if (may_idle && $urandom_range(99) < 22) pause_requests();
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** bounded_double_ended_queue_top: PASSED **");
      end else begin
         $display("** bounded_double_ended_queue_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bdq_pkg.sv
hdl/bdq_ctrl.sv
hdl/bdq_dpath.sv
hdl/bounded_double_ended_queue_top.sv
hdl/bdq_checker.sv
bench/testbench.sv
